FILE: hdl/lbfa_pkg.sv
// ----------------------------------------------------------------------------
// lbfa_pkg: shared types and constants of the linked block file allocator
// Request and status codes, link kinds and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lbfa_pkg;

  localparam int unsigned DirEntries = 32;
  localparam int unsigned DiskBlocks = 512;
  localparam int unsigned FidxW      = 5;
  localparam int unsigned BidxW      = 9;

  typedef enum logic [2:0] {
    REQ_APPEND   = 3'd0,
    REQ_DELETE   = 3'd1,
    REQ_FORMAT   = 3'd2,
    REQ_READ_BLK = 3'd3,
    REQ_READ_DIR = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIR_FULL  = 3'd1,
    ST_PART_FULL = 3'd2,
    ST_SLOT_EMPTY = 3'd3,
    ST_NO_FILE   = 3'd4,
    ST_NO_BLOCKS = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    LK_FREE  = 2'd0,
    LK_CHAIN = 2'd1,
    LK_END   = 2'd2,
    LK_MARK  = 2'd3
  } link_e;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CLEAR  = 8'b0000_0010,
    S_DIRSCN = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_CHAIN  = 8'b0001_0000,
    S_WALK   = 8'b0010_0000,
    S_RDBLK  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_e;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_P1_END = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_P2_END = 1'b1;

endpackage

`default_nettype wire

FILE: hdl/lbfa_blkmem.sv
// ----------------------------------------------------------------------------
// lbfa_blkmem: block link and byte store
// One write port and one registered read port, shared by every step of the
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lbfa_blkmem #(
  parameter int unsigned DISK_BLOCKS = lbfa_pkg::DiskBlocks
) (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [$clog2(DISK_BLOCKS)-1:0] waddr_i,
  input  wire logic [1:0]                     wkind_i,
  input  wire logic [$clog2(DISK_BLOCKS)-1:0] wnext_i,
  input  wire logic                           wbyte_en_i,
  input  wire logic [7:0]                     wbyte_i,
  input  wire logic [$clog2(DISK_BLOCKS)-1:0] raddr_i,
  output logic      [1:0]                     rkind_o,
  output logic      [$clog2(DISK_BLOCKS)-1:0] rnext_o,
  output logic      [7:0]                     rbyte_o
);
  localparam int unsigned AW = $clog2(DISK_BLOCKS);

  logic [AW+1:0] link_mem [DISK_BLOCKS];
  logic [7:0]    byte_mem [DISK_BLOCKS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      link_mem[waddr_i] <= {wkind_i, wnext_i};
    end
    {rkind_o, rnext_o} <= link_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (we_i && wbyte_en_i) begin
      byte_mem[waddr_i] <= wbyte_i;
    end
    rbyte_o <= byte_mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hdl/linked_block_file_allocator_unit.sv
// ----------------------------------------------------------------------------
// linked_block_file_allocator_unit: two-partition linked block store
// Sequencer around one block memory port, a directory and a scan pointer.
// ----------------------------------------------------------------------------
// Each word is handled alone; the block is not ready until its result has
// been taken. An append examines blocks from the cursor up to and including
// the first free block or the partition end marker, and passes through a
// chaining step when the byte is chained after an earlier block. Starting a
// file first examines directory slots, lowest first; a full directory answers
// with a full-directory status. A delete visits each block on the chain when
// the file has blocks. Reset and format run a clearing pass over the block
// memory, during which no word is accepted.
`default_nettype none

module linked_block_file_allocator_unit #(
  parameter int unsigned DIR_ENTRIES = lbfa_pkg::DirEntries,
  parameter int unsigned DISK_BLOCKS = lbfa_pkg::DiskBlocks
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [8:0] cfg_data_i,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [2:0] req_type_i,
  input  wire logic       partition_i,
  input  wire logic       start_file_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic [4:0] file_index_i,
  input  wire logic [8:0] block_index_i,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [2:0] status_o,
  output logic      [4:0] slot_o,
  output logic      [8:0] block_o,
  output logic      [7:0] read_byte_o,
  output logic      [1:0] link_kind_o,
  output logic      [8:0] next_block_o
);
  import lbfa_pkg::*;

  localparam int unsigned AW = $clog2(DISK_BLOCKS);
  localparam int unsigned DW = $clog2(DIR_ENTRIES);
  localparam logic [AW-1:0] LastBlk = AW'(DISK_BLOCKS - 1);

  state_e state_q, state_d;

  logic [8:0] p1_end_q, p2_end_q;

  logic [DIR_ENTRIES-1:0] dvalid_q, dvalid_d, dhas_q, dhas_d;
  logic [AW-1:0] dfirst_mem [DIR_ENTRIES];
  logic          dfirst_we;
  logic [DW-1:0] dfirst_waddr;
  logic [AW-1:0] dfirst_wdata;

  logic          fopen_q, fopen_d;
  logic [DW-1:0] oslot_q, oslot_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] prev_q, prev_d;
  logic          hasprev_q, hasprev_d;

  // Latched request.
  logic [2:0] req_q;
  logic       part_q;
  logic [7:0] data_q;

  logic [AW-1:0] ptr_q, ptr_d;
  logic [DW:0]   dcnt_q, dcnt_d;
  logic          wait_q, wait_d;

  logic [2:0] st_q, st_d;
  logic [4:0] sl_q, sl_d;
  logic [8:0] bk_q, bk_d;
  logic [7:0] rb_q, rb_d;
  logic [1:0] lk_q, lk_d;
  logic [8:0] nb_q, nb_d;

  logic          m_we, m_wbe;
  logic [AW-1:0] m_waddr, m_wnext, m_raddr;
  logic [1:0]    m_wkind, m_rkind;
  logic [AW-1:0] m_rnext;
  logic [7:0]    m_wbyte, m_rbyte;

  lbfa_blkmem #(.DISK_BLOCKS(DISK_BLOCKS)) u_mem (
    .clk_i     (clk_i),
    .we_i      (m_we),
    .waddr_i   (m_waddr),
    .wkind_i   (m_wkind),
    .wnext_i   (m_wnext),
    .wbyte_en_i(m_wbe),
    .wbyte_i   (m_wbyte),
    .raddr_i   (m_raddr),
    .rkind_o   (m_rkind),
    .rnext_o   (m_rnext),
    .rbyte_o   (m_rbyte)
  );

  always_ff @(posedge clk_i) begin
    if (dfirst_we) begin
      dfirst_mem[dfirst_waddr] <= dfirst_wdata;
    end
  end

  logic in_acc;
  assign in_stall  = (state_q != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_q == S_OUT);

  assign status_o     = st_q;
  assign slot_o       = sl_q;
  assign block_o      = bk_q;
  assign read_byte_o  = rb_q;
  assign link_kind_o  = lk_q;
  assign next_block_o = nb_q;

  // Marker test for the clearing pass.
  function automatic logic is_mark(input logic [AW-1:0] b, input logic [8:0] p1,
                                   input logic [8:0] p2);
    logic hit;
    hit = (b == LastBlk);
    if ({{(AW > 9 ? AW - 9 : 0){1'b0}}, p1} == {{(9 > AW ? 9 - AW : 0){1'b0}}, b})
      hit = 1'b1;
    if ({{(AW > 9 ? AW - 9 : 0){1'b0}}, p2} == {{(9 > AW ? 9 - AW : 0){1'b0}}, b})
      hit = 1'b1;
    return hit;
  endfunction

  logic [9:0]    p2start;
  logic [AW-1:0] p2cur;
  assign p2start = {1'b0, p1_end_q} + 10'd1;
  assign p2cur   = ({{(AW > 10 ? AW - 10 : 0){1'b0}}, p2start} >= DISK_BLOCKS) ? LastBlk
                   : AW'(p2start);

  always_comb begin
    state_d   = state_q;
    dvalid_d  = dvalid_q;
    dhas_d    = dhas_q;
    fopen_d   = fopen_q;
    oslot_d   = oslot_q;
    cur_d     = cur_q;
    prev_d    = prev_q;
    hasprev_d = hasprev_q;
    ptr_d     = ptr_q;
    dcnt_d    = dcnt_q;
    wait_d    = 1'b0;
    st_d = st_q; sl_d = sl_q; bk_d = bk_q; rb_d = rb_q; lk_d = lk_q; nb_d = nb_q;
    m_we = 1'b0; m_wbe = 1'b0; m_waddr = ptr_q; m_wkind = LK_FREE; m_wnext = '0;
    m_wbyte = data_q; m_raddr = ptr_q;
    dfirst_we = 1'b0; dfirst_waddr = oslot_q; dfirst_wdata = cur_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          st_d = ST_OK; sl_d = '0; bk_d = '0; rb_d = '0; lk_d = LK_FREE; nb_d = '0;
          case (req_type_i)
            REQ_APPEND: begin
              if (start_file_i) begin
                dcnt_d  = '0;
                state_d = S_DIRSCN;
              end else if (!fopen_q) begin
                st_d    = ST_NO_FILE;
                state_d = S_OUT;
              end else begin
                ptr_d   = cur_q;
                wait_d  = 1'b1;
                state_d = S_SCAN;
              end
            end
            REQ_DELETE: begin
              sl_d = file_index_i;
              if (({27'd0, file_index_i} >= DIR_ENTRIES) || !dvalid_q[DW'(file_index_i)]) begin
                st_d    = ST_SLOT_EMPTY;
                state_d = S_OUT;
              end else begin
                if (fopen_q && oslot_q == DW'(file_index_i)) fopen_d = 1'b0;
                dvalid_d[DW'(file_index_i)] = 1'b0;
                dhas_d[DW'(file_index_i)]   = 1'b0;
                if (!dhas_q[DW'(file_index_i)]) begin
                  st_d    = ST_NO_BLOCKS;
                  state_d = S_OUT;
                end else begin
                  ptr_d   = dfirst_mem[DW'(file_index_i)];
                  bk_d    = 9'(dfirst_mem[DW'(file_index_i)]);
                  dcnt_d  = '0;
                  wait_d  = 1'b1;
                  state_d = S_WALK;
                end
              end
            end
            REQ_FORMAT: begin
              ptr_d   = '0;
              state_d = S_CLEAR;
            end
            REQ_READ_BLK: begin
              bk_d = block_index_i;
              if ({23'd0, block_index_i} < DISK_BLOCKS) begin
                ptr_d   = AW'(block_index_i);
                wait_d  = 1'b1;
                state_d = S_RDBLK;
              end else begin
                state_d = S_OUT;
              end
            end
            REQ_READ_DIR: begin
              sl_d = file_index_i;
              if (({27'd0, file_index_i} >= DIR_ENTRIES) || !dvalid_q[DW'(file_index_i)])
                st_d = ST_SLOT_EMPTY;
              else if (!dhas_q[DW'(file_index_i)])
                st_d = ST_NO_BLOCKS;
              else
                bk_d = 9'(dfirst_mem[DW'(file_index_i)]);
              state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end

      S_CLEAR: begin
        m_we      = 1'b1;
        m_waddr   = ptr_q;
        m_wkind   = is_mark(ptr_q, p1_end_q, p2_end_q) ? LK_MARK : LK_FREE;
        dvalid_d  = '0;
        dhas_d    = '0;
        fopen_d   = 1'b0;
        oslot_d   = '0;
        cur_d     = '0;
        prev_d    = '0;
        hasprev_d = 1'b0;
        ptr_d     = ptr_q + AW'(1);
        if (ptr_q == LastBlk) state_d = (req_q == REQ_FORMAT) ? S_OUT : S_IDLE;
      end

      // One directory slot per cycle, lowest free first.
      S_DIRSCN: begin
        if (dcnt_q == (DW+1)'(DIR_ENTRIES)) begin
          fopen_d = 1'b0;
          st_d    = ST_DIR_FULL;
          state_d = S_OUT;
        end else if (!dvalid_q[dcnt_q[DW-1:0]]) begin
          dvalid_d[dcnt_q[DW-1:0]] = 1'b1;
          dhas_d[dcnt_q[DW-1:0]]   = 1'b0;
          fopen_d   = 1'b1;
          oslot_d   = dcnt_q[DW-1:0];
          hasprev_d = 1'b0;
          prev_d    = '0;
          cur_d     = part_q ? p2cur : '0;
          ptr_d     = part_q ? p2cur : '0;
          wait_d    = 1'b1;
          state_d   = S_SCAN;
        end else begin
          dcnt_d = dcnt_q + (DW+1)'(1);
        end
      end

      // The read address is ptr_q; the registered data shows in the next cycle.
      S_SCAN: begin
        sl_d = 5'(oslot_q);
        if (!wait_q) begin
          if (m_rkind == LK_FREE) begin
            cur_d   = ptr_q;
            m_we    = 1'b1;
            m_wbe   = 1'b1;
            m_waddr = ptr_q;
            m_wkind = LK_END;
            bk_d    = 9'(ptr_q);
            if (!hasprev_q) begin
              dfirst_we              = 1'b1;
              dfirst_waddr           = oslot_q;
              dfirst_wdata           = ptr_q;
              dhas_d[oslot_q]        = 1'b1;
              prev_d                 = ptr_q;
              hasprev_d              = 1'b1;
              state_d                = S_OUT;
            end else begin
              state_d = S_CHAIN;
            end
          end else if (m_rkind == LK_MARK || ptr_q == LastBlk) begin
            cur_d   = ptr_q;
            st_d    = ST_PART_FULL;
            state_d = S_OUT;
          end else begin
            ptr_d  = ptr_q + AW'(1);
            wait_d = 1'b1;
          end
        end
      end

      S_CHAIN: begin
        m_we      = 1'b1;
        m_waddr   = prev_q;
        m_wkind   = LK_CHAIN;
        m_wnext   = cur_q;
        prev_d    = cur_q;
        hasprev_d = 1'b1;
        state_d   = S_OUT;
      end

      S_WALK: begin
        if (!wait_q) begin
          if (m_rkind == LK_CHAIN || m_rkind == LK_END) begin
            m_we    = 1'b1;
            m_waddr = ptr_q;
            m_wkind = LK_FREE;
          end
          if (m_rkind == LK_CHAIN && dcnt_q != '1) begin
            ptr_d  = m_rnext;
            wait_d = 1'b1;
          end else begin
            state_d = S_OUT;
          end
        end
      end

      S_RDBLK: begin
        if (!wait_q) begin
          lk_d = m_rkind;
          if (m_rkind == LK_CHAIN || m_rkind == LK_END) rb_d = m_rbyte;
          if (m_rkind == LK_CHAIN) nb_d = 9'(m_rnext);
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_stall) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      p1_end_q  <= 9'd255;
      p2_end_q  <= 9'd510;
      dvalid_q  <= '0;
      dhas_q    <= '0;
      fopen_q   <= 1'b0;
      oslot_q   <= '0;
      cur_q     <= '0;
      prev_q    <= '0;
      hasprev_q <= 1'b0;
      ptr_q     <= '0;
      dcnt_q    <= '0;
      wait_q    <= 1'b0;
      req_q     <= 3'd7;
    end else begin
      state_q   <= state_d;
      dvalid_q  <= dvalid_d;
      dhas_q    <= dhas_d;
      fopen_q   <= fopen_d;
      oslot_q   <= oslot_d;
      cur_q     <= cur_d;
      prev_q    <= prev_d;
      hasprev_q <= hasprev_d;
      ptr_q     <= ptr_d;
      dcnt_q    <= dcnt_d;
      wait_q    <= wait_d;
      if (in_acc) req_q <= req_type_i;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_P1_END) p1_end_q <= cfg_data_i;
        if (cfg_index_i == CFG_P2_END) p2_end_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      part_q  <= partition_i;
      data_q  <= data_byte_i;
    end
    st_q <= st_d; sl_q <= sl_d; bk_q <= bk_d;
    rb_q <= rb_d; lk_q <= lk_d; nb_q <= nb_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state not one-hot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_stall) |=> (state_q == S_OUT && $stable(st_q)))
    else $error("result lost under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fopen_q && state_q == S_IDLE) |-> dvalid_q[oslot_q])
    else $error("open file has no slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHAIN) |-> hasprev_q)
    else $error("chain without previous block");

endmodule

`default_nettype wire
